FILE: src/mlvlc_pkg.sv
// Shared constants, codes and pipeline context type of the multilevel table VLC decoder.
package mlvlc_pkg;

    localparam int NUM_TABLES  = 64;
    localparam int LOOKUP_BITS = 8;
    localparam int MAX_CHAIN   = 4;
    localparam int WINDOW_BITS = 32;

    localparam int TAB_W       = $clog2(NUM_TABLES);
    localparam int TAB_ENTRIES = 1 << LOOKUP_BITS;
    localparam int MEM_DEPTH   = NUM_TABLES * TAB_ENTRIES;
    localparam int ADDR_W      = TAB_W + LOOKUP_BITS;
    localparam int POS_W       = $clog2(WINDOW_BITS + 1);
    localparam int ENTRY_W     = 29;
    localparam int FIXED_MAX   = 16;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_DECODE = 2'd1,
        OP_FIXED  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OOB       = 2'd1,
        ST_EXIT      = 2'd2,
        ST_EXHAUSTED = 2'd3
    } t_status;

    // Item context carried down the lookup pipeline. etype/evalue hold the load
    // data for a load and the decoded entry once a decode has finished.
    typedef struct packed {
        logic                   valid;
        t_op                    op;
        logic [TAB_W-1:0]       tab;
        logic [LOOKUP_BITS-1:0] idx;
        logic [POS_W-1:0]       pos;
        logic                   done;
        logic                   exh;
        logic [7:0]             etype;
        logic [15:0]            evalue;
        logic [4:0]             elen;
        logic [WINDOW_BITS-1:0] window;
        logic [15:0]            budget;
        logic [4:0]             flen;
    } t_ctx;

endpackage

FILE: src/multilevel_table_vlc_decoder_top.sv
// Top level of the multilevel table VLC decoder: lookup pipeline, result stage, register.
//
// Input channel: i_valid / o_stall. A beat is taken at a clock edge with i_valid high
// and o_stall low. Op load writes one table entry, op decode looks up LOOKUP_BITS bits
// at a time and follows escape chains, op fixed reads 0 to 16 bits from the window top.
// Loads and op 3 give no result; decodes and fixed reads give exactly one.
// Output channel: o_valid / i_stall, one result beat per decode or fixed read.
// Configuration: i_cfg_valid / o_cfg_ready (always ready) writes the exit type code.
// Throughput: one beat per cycle while the receiver does not stall. Each chain level does
// one registered table read and owns a replica of the tables, and the result register
// follows the last level.
// When the receiver stalls a held result, the whole pipeline freezes and o_stall rises
// in the same cycle; nothing is dropped or repeated.
// Reset clears the pipeline valid bits and the exit code; table contents are undefined
// until loaded, and every entry of a table must be loaded before it is decoded from.
module multilevel_table_vlc_decoder_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_op,
    input  logic [5:0]          i_table_select,
    input  logic [7:0]          i_entry_index,
    input  logic [7:0]          i_entry_type,
    input  logic signed [15:0]  i_entry_value,
    input  logic signed [4:0]   i_entry_length,
    input  logic [31:0]         i_bit_window,
    input  logic [15:0]         i_bit_budget,
    input  logic [4:0]          i_fixed_length,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_status,
    output logic [7:0]          o_symbol_type,
    output logic signed [16:0]  o_symbol_value,
    output logic [5:0]          o_bits_used,
    output logic signed [16:0]  o_bits_left,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data
);
    import mlvlc_pkg::*;

    logic               en;
    logic [7:0]         r_exit_code;
    t_ctx               stage_ctx [MAX_CHAIN+1];
    t_ctx               fctx;
    logic               load_ok;

    logic               r_valid;
    logic               n_valid;
    t_status            r_status;
    t_status            n_status;
    logic [7:0]         r_type;
    logic [7:0]         n_type;
    logic signed [16:0] r_value;
    logic signed [16:0] n_value;
    logic [5:0]         r_used;
    logic [5:0]         n_used;
    logic signed [16:0] r_left;
    logic signed [16:0] n_left;

    logic [4:0]         fl;
    logic [15:0]        fval;

    assign en          = !(r_valid && i_stall);
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exit_code <= '0;
        end else if (i_cfg_valid) begin
            r_exit_code <= i_cfg_data;
        end
    end

    always_comb begin
        load_ok = (int'(i_table_select) < NUM_TABLES) && (int'(i_entry_index) < TAB_ENTRIES);
        stage_ctx[0].valid  = i_valid;
        stage_ctx[0].op     = t_op'(i_op);
        // A load aimed outside the store is dropped before it reaches the tables.
        if ((t_op'(i_op) == OP_LOAD) && !load_ok) begin
            stage_ctx[0].op = OP_NONE;
        end
        stage_ctx[0].tab    = TAB_W'(i_table_select % NUM_TABLES);
        stage_ctx[0].idx    = LOOKUP_BITS'(i_entry_index);
        stage_ctx[0].pos    = '0;
        stage_ctx[0].done   = 1'b0;
        stage_ctx[0].exh    = 1'b0;
        stage_ctx[0].etype  = i_entry_type;
        stage_ctx[0].evalue = i_entry_value;
        stage_ctx[0].elen   = i_entry_length;
        stage_ctx[0].window = WINDOW_BITS'(i_bit_window);
        stage_ctx[0].budget = i_bit_budget;
        stage_ctx[0].flen   = i_fixed_length;
    end

    for (genvar g = 0; g < MAX_CHAIN; g++) begin : g_stage
        mlvlc_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctx   (stage_ctx[g]),
            .o_ctx   (stage_ctx[g+1])
        );
    end

    assign fctx = stage_ctx[MAX_CHAIN];

    always_comb begin
        fl      = (fctx.flen > 5'(FIXED_MAX)) ? 5'(FIXED_MAX) : fctx.flen;
        fval    = fctx.window[WINDOW_BITS-1 -: FIXED_MAX] >> (5'(FIXED_MAX) - fl);
        n_valid = fctx.valid && ((fctx.op == OP_DECODE) || (fctx.op == OP_FIXED));
        n_status = ST_OK;
        n_type   = '0;
        n_value  = '0;
        if (fctx.op == OP_FIXED) begin
            n_used = 6'(fl);
            n_left = $signed({1'b0, fctx.budget}) - $signed(17'(fl));
            if (n_left < 0) begin
                n_status = ST_OOB;
            end else begin
                n_value = $signed({1'b0, fval});
            end
        end else begin
            n_used = 6'(fctx.pos);
            n_left = $signed({1'b0, fctx.budget}) - $signed(17'(fctx.pos));
            // Still undecided after the last level, or stopped at the window end.
            if (!fctx.done || fctx.exh) begin
                n_status = ST_EXHAUSTED;
            end else if (n_left < 0) begin
                n_status = ST_OOB;
            end else begin
                n_value = $signed({fctx.evalue[15], fctx.evalue});
                n_type  = fctx.etype;
                if (fctx.etype == r_exit_code) begin
                    n_status = ST_EXIT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_status <= n_status;
            r_type   <= n_type;
            r_value  <= n_value;
            r_used   <= n_used;
            r_left   <= n_left;
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_symbol_type  = r_type;
    assign o_symbol_value = r_value;
    assign o_bits_used    = r_used;
    assign o_bits_left    = r_left;

endmodule

FILE: src/mlvlc_stage.sv
// One lookup stage: a table memory replica, its registered read and the escape step.
module mlvlc_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  mlvlc_pkg::t_ctx i_ctx,
    output mlvlc_pkg::t_ctx o_ctx
);
    import mlvlc_pkg::*;

    localparam int PW1 = POS_W + 1;

    logic [ENTRY_W-1:0]     r_mem [MEM_DEPTH];
    logic [ENTRY_W-1:0]     r_rd;
    t_ctx                   r_ctx;
    t_ctx                   n_ctx;
    logic                   r_act;
    logic                   n_act;

    logic [WINDOW_BITS-1:0] win_sh;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      wr_addr;
    logic [PW1-1:0]         pos_end;
    logic                   fits;
    logic                   pending;
    logic                   wr;

    logic [4:0]             len;
    logic [4:0]             mag_raw;
    logic [4:0]             mag;

    always_comb begin
        win_sh  = i_ctx.window << i_ctx.pos;
        rd_addr = {i_ctx.tab, win_sh[WINDOW_BITS-1 -: LOOKUP_BITS]};
        wr_addr = {i_ctx.tab, i_ctx.idx};
        pos_end = {1'b0, i_ctx.pos} + PW1'(LOOKUP_BITS);
        fits    = (pos_end <= PW1'(WINDOW_BITS));
        pending = i_ctx.valid && (i_ctx.op == OP_DECODE) && !i_ctx.done;
        wr      = i_ctx.valid && (i_ctx.op == OP_LOAD);
        n_act   = pending && fits;
        n_ctx   = i_ctx;
        // A lookup that would run past the window ends the decode here.
        if (pending && !fits) begin
            n_ctx.done = 1'b1;
            n_ctx.exh  = 1'b1;
        end
    end

    // Loads write this replica as they pass, so every replica sees the same order.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (wr) begin
                r_mem[wr_addr] <= {i_ctx.etype, i_ctx.evalue, i_ctx.elen};
            end
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx <= '0;
            r_act <= 1'b0;
        end else if (i_en) begin
            r_ctx <= n_ctx;
            r_act <= n_act;
        end
    end

    always_comb begin
        len     = r_rd[4:0];
        mag_raw = len[4] ? 5'(-len) : len;
        mag     = (mag_raw > 5'(LOOKUP_BITS)) ? 5'(LOOKUP_BITS) : mag_raw;
        o_ctx   = r_ctx;
        if (r_act) begin
            o_ctx.pos = r_ctx.pos + POS_W'(mag);
            if (!len[4]) begin
                o_ctx.done   = 1'b1;
                o_ctx.etype  = r_rd[28:21];
                o_ctx.evalue = r_rd[20:5];
            end else begin
                o_ctx.tab = TAB_W'(r_rd[20:5] % NUM_TABLES);
            end
        end
    end

endmodule
